/* hw/rtl/ltc_pkg.sv */
// Shared constants and types for the literal token classifier.
package ltc_pkg;

    // Character codes
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Number recogniser phases
    localparam int          PHASE_W  = 3;
    localparam logic [2:0]  PH_START = 3'd0;
    localparam logic [2:0]  PH_SIGN  = 3'd1;
    localparam logic [2:0]  PH_INT   = 3'd2;
    localparam logic [2:0]  PH_DOT   = 3'd3;
    localparam logic [2:0]  PH_FRAC  = 3'd4;
    localparam logic [2:0]  PH_REJ   = 3'd5;

    // Verdicts for one finished token
    typedef struct packed {
        logic number_ok;
        logic natural_ok;
        logic string_ok;
    } ltc_verdict_t;

endpackage

/* hw/rtl/literal_token_classifier.sv */
// A result is registered in the result register after the last byte of a token has passed the input register.
// Throughput: one byte per cycle while byte_stall is low, also across token boundaries.
// The byte side stalls only when a finished result is still held by a stalled output
// and a second last byte is waiting in the input register.
// Reset (rst_n, asynchronous) empties both registers and clears the token state.
module literal_token_classifier
    import ltc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_byte,
    input  logic       is_last,
    input  logic       byte_valid,
    output logic       byte_stall,
    output logic       number_ok,
    output logic       natural_ok,
    output logic       string_ok,
    output logic       result_valid,
    input  logic       result_stall
);

    logic         s1_valid_reg;
    logic [7:0]   s1_byte_reg;
    logic         s1_last_reg;
    logic         out_valid_reg;
    ltc_verdict_t out_verdict_reg;
    ltc_verdict_t verdict;
    logic         out_free;
    logic         s1_move;
    logic         in_fire;

    // Pipeline advance
    assign out_free   = !out_valid_reg || !result_stall;
    assign s1_move    = s1_valid_reg && (!s1_last_reg || out_free);
    assign byte_stall = s1_valid_reg && !s1_move;
    assign in_fire    = byte_valid && !byte_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= char_byte;
            s1_last_reg <= is_last;
        end
    end

    ltc_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_move),
        .char_byte (s1_byte_reg),
        .is_last   (s1_last_reg),
        .verdict   (verdict)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_last_reg)
            out_verdict_reg <= verdict;
    end

    assign result_valid = out_valid_reg;
    assign number_ok    = out_verdict_reg.number_ok;
    assign natural_ok   = out_verdict_reg.natural_ok;
    assign string_ok    = out_verdict_reg.string_ok;

    // Checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg))
        else $error("byte side stalled without a blocked last byte");

    a_natural_is_number: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_verdict_reg.natural_ok || out_verdict_reg.number_ok))
        else $error("natural verdict without number verdict");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_move && s1_last_reg))
        else $error("result raised without a last byte");

    a_held_byte_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("held byte lost from input register");

endmodule

/* hw/rtl/ltc_scan.sv */
// Per-token scanning state and the verdict logic for one byte.
module ltc_scan
    import ltc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   char_byte,
    input  logic         is_last,
    output ltc_verdict_t verdict
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               minus_reg, minus_next;
    logic               nonzero_reg, nonzero_next;
    logic               opened_reg, opened_next;
    logic               failed_reg, failed_next;
    logic               prev_bs_reg, prev_bs_next;
    logic               past_first_reg, past_first_next;
    logic               is_dig;
    logic               str_ok;

    // Number phase transition
    always_comb
    begin
        is_dig = char_byte inside {[CH_ZERO:CH_NINE]};
        case (phase_reg)
            PH_START:
            begin
                if (char_byte == CH_PLUS || char_byte == CH_MINUS)
                    phase_next = PH_SIGN;
                else
                    phase_next = is_dig ? PH_INT : PH_REJ;
            end
            PH_SIGN:
                phase_next = is_dig ? PH_INT : PH_REJ;
            PH_INT:
            begin
                if (is_dig)
                    phase_next = PH_INT;
                else
                    phase_next = (char_byte == CH_DOT) ? PH_DOT : PH_REJ;
            end
            PH_DOT, PH_FRAC:
                phase_next = is_dig ? PH_FRAC : PH_REJ;
            default:
                phase_next = PH_REJ;
        endcase
    end

    // Sign, digit and quote tracking
    always_comb
    begin
        minus_next   = minus_reg | (phase_reg == PH_START && char_byte == CH_MINUS);
        nonzero_next = nonzero_reg | (is_dig && char_byte != CH_ZERO);
        opened_next  = opened_reg;
        failed_next  = failed_reg;
        str_ok       = 1'b0;
        if (!past_first_reg)
            opened_next = (char_byte == CH_QUOTE);
        else if (is_last)
            str_ok = opened_reg && !failed_reg && char_byte == CH_QUOTE;
        else if (char_byte == CH_QUOTE && !prev_bs_reg)
            failed_next = 1'b1;
        prev_bs_next    = (char_byte == CH_BSLASH);
        past_first_next = 1'b1;
    end

    // Verdicts, valid when the last byte steps
    assign verdict.number_ok  = (phase_next == PH_INT) || (phase_next == PH_DOT) ||
                                (phase_next == PH_FRAC);
    assign verdict.natural_ok = (phase_next == PH_INT) && !minus_next && nonzero_next;
    assign verdict.string_ok  = str_ok;

    // State update; the last byte of a token clears everything
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            minus_reg      <= 1'b0;
            nonzero_reg    <= 1'b0;
            opened_reg     <= 1'b0;
            failed_reg     <= 1'b0;
            prev_bs_reg    <= 1'b0;
            past_first_reg <= 1'b0;
        end
        else if (step)
        begin
            if (is_last)
            begin
                phase_reg      <= PH_START;
                minus_reg      <= 1'b0;
                nonzero_reg    <= 1'b0;
                opened_reg     <= 1'b0;
                failed_reg     <= 1'b0;
                prev_bs_reg    <= 1'b0;
                past_first_reg <= 1'b0;
            end
            else
            begin
                phase_reg      <= phase_next;
                minus_reg      <= minus_next;
                nonzero_reg    <= nonzero_next;
                opened_reg     <= opened_next;
                failed_reg     <= failed_next;
                prev_bs_reg    <= prev_bs_next;
                past_first_reg <= past_first_next;
            end
        end
    end

endmodule
